// ----- rtl/tcts_pkg.sv -----
`timescale 1ns / 1ps
// tcts_pkg: shared types, request codes and note arithmetic for the
// two-channel tone sequencer. No dependencies.
package tcts_pkg;

    localparam int NOTE_DEPTH_DEF = 64;

    localparam int FREQ_W  = 12;
    localparam int DUR_W   = 11;
    localparam int IDX_W   = 6;
    localparam int INC_W   = 14;
    localparam int PHASE_W = 16;
    localparam int TIMER_W = 16;

    localparam logic [1:0] REQ_LOAD  = 2'd0;
    localparam logic [1:0] REQ_START = 2'd1;
    localparam logic [1:0] REQ_TICK  = 2'd2;

    // increment = floor(freq * 65536 / TICK_RATE), done as a reciprocal multiply
    localparam longint TICK_RATE = 31250;
    localparam int     INC_SHIFT = 26;
    localparam int     RECIP_W   = 28;
    localparam int     PROD_W    = FREQ_W + RECIP_W;
    localparam logic [RECIP_W-1:0] INC_RECIP =
        RECIP_W'(((64'd1 << (INC_SHIFT + 16)) + 64'(TICK_RATE) - 64'd1) / 64'(TICK_RATE));

    typedef struct packed {
        logic [FREQ_W-1:0] freq;
        logic [DUR_W-1:0]  dur;
    } t_note;

    typedef struct packed {
        logic              en;
        logic [IDX_W-1:0]  index;
        t_note             note;
    } t_note_wr;

    typedef struct packed {
        logic [1:0]        req_type;
        logic              channel;
        logic [IDX_W-1:0]  note_index;
        logic [FREQ_W-1:0] freq_hz;
        logic [DUR_W-1:0]  duration_ms;
    } t_in_item;

    typedef struct packed {
        logic dir_left;
        logic dir_right;
        logic drive_left;
        logic drive_right;
        logic playing;
    } t_out_item;

    function automatic logic [INC_W-1:0] calc_inc(input logic [FREQ_W-1:0] freq);
        logic [PROD_W-1:0] prod;
        prod = PROD_W'(freq) * PROD_W'(INC_RECIP);
        return prod[INC_SHIFT +: INC_W];
    endfunction

    // duration_ms * 31
    function automatic logic [TIMER_W-1:0] calc_timer(input logic [DUR_W-1:0] dur);
        logic [TIMER_W-1:0] d;
        d = TIMER_W'(dur);
        return (d << 5) - d;
    endfunction

endpackage

// ----- rtl/tcts_note_mem.sv -----
`timescale 1ns / 1ps
// tcts_note_mem: one channel's note store, one write and one registered read
// port with write bypass. Depends on tcts_pkg.
module tcts_note_mem #(
    parameter int  DEPTH = tcts_pkg::NOTE_DEPTH_DEF,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic               i_clk,
    input  tcts_pkg::t_note_wr i_wr,
    input  logic [AW-1:0]      i_rd_addr,
    output tcts_pkg::t_note    o_rd_data
);

    tcts_pkg::t_note r_mem [DEPTH];
    tcts_pkg::t_note r_rd_data;
    logic [AW-1:0]   wr_addr;
    logic            wr_ok;

    assign wr_addr   = AW'(i_wr.index);
    assign wr_ok     = i_wr.en && (32'(i_wr.index) < DEPTH);
    assign o_rd_data = r_rd_data;

    always_ff @(posedge i_clk) begin
        if (wr_ok) begin
            r_mem[wr_addr] <= i_wr.note;
        end
        if (wr_ok && (wr_addr == i_rd_addr)) begin
            r_rd_data <= i_wr.note;
        end else begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

// ----- rtl/tcts_ctrl.sv -----
`timescale 1ns / 1ps
// tcts_ctrl: per-transfer state update (timers, note fetch, phases) and the
// result register. Depends on tcts_pkg; fed by two tcts_note_mem reads.
module tcts_ctrl #(
    parameter int  NOTE_DEPTH = tcts_pkg::NOTE_DEPTH_DEF,
    localparam int PW         = $clog2(NOTE_DEPTH)
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_accept,
    input  tcts_pkg::t_in_item         i_item,
    input  tcts_pkg::t_note [1:0]      i_next_note,
    output tcts_pkg::t_note_wr [1:0]   o_wr,
    output logic [1:0][PW-1:0]         o_rd_addr,
    output tcts_pkg::t_out_item        o_result
);

    logic [1:0][PW-1:0]                    r_pos,   n_pos;
    logic [1:0][tcts_pkg::PHASE_W-1:0]     r_phase, n_phase;
    logic [1:0][tcts_pkg::INC_W-1:0]       r_inc,   n_inc;
    logic [1:0][tcts_pkg::TIMER_W-1:0]     r_timer, n_timer;
    logic                                  r_fin1,  n_fin1;
    logic                                  r_run,   n_run;
    tcts_pkg::t_note [1:0]                 r_head,  n_head;
    tcts_pkg::t_out_item                   r_result, n_result;

    logic [1:0][tcts_pkg::INC_W-1:0]       inc_head, inc_next;
    logic [1:0][tcts_pkg::TIMER_W-1:0]     tmr_head, tmr_next;

    function automatic logic [PW-1:0] step_pos(input logic [PW-1:0] p);
        return (p == PW'(NOTE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_comb begin
        for (int ch = 0; ch < 2; ch++) begin
            inc_head[ch] = tcts_pkg::calc_inc(r_head[ch].freq);
            inc_next[ch] = tcts_pkg::calc_inc(i_next_note[ch].freq);
            tmr_head[ch] = tcts_pkg::calc_timer(r_head[ch].dur);
            tmr_next[ch] = tcts_pkg::calc_timer(i_next_note[ch].dur);
        end

        n_pos   = r_pos;
        n_phase = r_phase;
        n_inc   = r_inc;
        n_timer = r_timer;
        n_fin1  = r_fin1;
        n_run   = r_run;
        n_head  = r_head;

        for (int ch = 0; ch < 2; ch++) begin
            o_wr[ch].en    = i_accept && (i_item.req_type == tcts_pkg::REQ_LOAD)
                             && (i_item.channel == 1'(ch));
            o_wr[ch].index = i_item.note_index;
            o_wr[ch].note  = {i_item.freq_hz, i_item.duration_ms};
            if (o_wr[ch].en && (i_item.note_index == '0)) begin
                n_head[ch] = o_wr[ch].note;
            end
        end

        if (i_accept) begin
            case (i_item.req_type)
                tcts_pkg::REQ_START: begin
                    for (int ch = 0; ch < 2; ch++) begin
                        n_pos[ch]   = step_pos('0);
                        n_phase[ch] = '0;
                        n_inc[ch]   = inc_head[ch];
                        n_timer[ch] = tmr_head[ch];
                    end
                    n_fin1 = (r_head[1].dur == '0);
                    if (n_fin1) begin
                        n_inc[1] = '0;
                    end
                    n_run = (n_timer[0] != '0);
                end
                tcts_pkg::REQ_TICK: begin
                    if (r_run) begin
                        n_timer[0] = r_timer[0] - 1'b1;
                        if (n_timer[0] == '0) begin
                            n_pos[0]   = step_pos(r_pos[0]);
                            n_inc[0]   = inc_next[0];
                            n_timer[0] = tmr_next[0];
                            n_run      = (tmr_next[0] != '0);
                        end
                        if (!r_fin1) begin
                            n_timer[1] = r_timer[1] - 1'b1;
                            if (n_timer[1] == '0) begin
                                n_pos[1]   = step_pos(r_pos[1]);
                                n_inc[1]   = inc_next[1];
                                n_timer[1] = tmr_next[1];
                                if (i_next_note[1].dur == '0) begin
                                    n_fin1   = 1'b1;
                                    n_inc[1] = '0;
                                end
                            end
                        end
                        for (int ch = 0; ch < 2; ch++) begin
                            n_phase[ch] = r_phase[ch] + tcts_pkg::PHASE_W'(n_inc[ch]);
                        end
                    end
                end
                default: begin
                end
            endcase
        end

        // prefetch the entry at the next read position
        for (int ch = 0; ch < 2; ch++) begin
            o_rd_addr[ch] = i_rst_n ? n_pos[ch] : '0;
        end

        n_result.dir_left    = n_phase[0][tcts_pkg::PHASE_W-1];
        n_result.dir_right   = n_phase[1][tcts_pkg::PHASE_W-1];
        n_result.drive_left  = n_run && (n_inc[0] != '0);
        n_result.drive_right = n_run && !n_fin1 && (n_inc[1] != '0);
        n_result.playing     = n_run;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_phase <= '0;
            r_inc   <= '0;
            r_timer <= '0;
            r_fin1  <= 1'b0;
            r_run   <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_phase <= n_phase;
            r_inc   <= n_inc;
            r_timer <= n_timer;
            r_fin1  <= n_fin1;
            r_run   <= n_run;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head <= n_head;
        if (i_accept) begin
            r_result <= n_result;
        end
    end

    assign o_result = r_result;

    a_fin_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fin1 |-> (r_inc[1] == '0))
        else $error("finished channel 1 still has an increment");

    a_run_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run |-> (r_timer[0] != '0))
        else $error("playing with channel 0 timer at zero");

    a_pos_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_pos[0]) < NOTE_DEPTH) && (32'(r_pos[1]) < NOTE_DEPTH))
        else $error("read position beyond note store");

    a_start_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (i_item.req_type == tcts_pkg::REQ_START))
        |=> (r_phase[0] == '0) && (r_phase[1] == '0))
        else $error("phases not cleared by start");

    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && (i_item.req_type == tcts_pkg::REQ_TICK) && !r_run)
        |=> $stable(r_phase) && $stable(r_timer) && !r_run)
        else $error("idle tick changed state");

endmodule

// ----- rtl/two_channel_tone_sequencer_top.sv -----
`timescale 1ns / 1ps
// two_channel_tone_sequencer_top: two-channel square-wave melody player.
// Depends on tcts_pkg, tcts_note_mem and tcts_ctrl.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready / i_in_data) takes one request per
//   transfer: load a note entry into a channel's store, start playback, or one
//   31250 Hz sample tick. Output channel (o_out_valid / i_out_ready /
//   o_out_data) returns exactly one result per request: both square-wave
//   directions, both drive enables and the playing flag after that request.
//   The result is registered and valid in the cycle after the input transfer.
//   Throughput is one request per cycle while results are taken; the note
//   stores prefetch the entry at the next read position; no fetch stalls input.
//   When the receiver stalls, the result register holds and o_in_ready falls
//   until the result is taken; a new request is taken in the same cycle the
//   held result leaves.
//   Reset clears timers, phases, read positions and the playing flag, and holds
//   o_in_ready low; the note stores are not cleared and must be loaded before
//   playback reads them.
module two_channel_tone_sequencer_top #(
    parameter int NOTE_DEPTH = tcts_pkg::NOTE_DEPTH_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  tcts_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output tcts_pkg::t_out_item o_out_data
);

    localparam int PW = $clog2(NOTE_DEPTH);

    logic                      accept;
    logic                      r_out_valid;
    tcts_pkg::t_note_wr [1:0]  note_wr;
    logic [1:0][PW-1:0]        rd_addr;
    tcts_pkg::t_note [1:0]     next_note;

    assign o_in_ready  = i_rst_n && (!r_out_valid || i_out_ready);
    assign accept      = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    for (genvar g = 0; g < 2; g++) begin : g_store
        tcts_note_mem #(
            .DEPTH(NOTE_DEPTH)
        ) u_note_mem (
            .i_clk    (i_clk),
            .i_wr     (note_wr[g]),
            .i_rd_addr(rd_addr[g]),
            .o_rd_data(next_note[g])
        );
    end

    tcts_ctrl #(
        .NOTE_DEPTH(NOTE_DEPTH)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_item     (i_in_data),
        .i_next_note(next_note),
        .o_wr       (note_wr),
        .o_rd_addr  (rd_addr),
        .o_result   (o_out_data)
    );

endmodule
